[src/fed_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fed_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int DECAY_W = 15;
    localparam int WET_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX      = 2'd2;

    localparam int RST_DELAY_LENGTH = 48000;
    localparam logic [DECAY_W-1:0] RST_DECAY_GAIN = 15'd16384;
    localparam logic [WET_W-1:0]   RST_WET_MIX    = 16'd16384;
    localparam logic [WET_W-1:0]   WET_ONE        = 16'd32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_end_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       block_end_out;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_item_t;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic wb;
    } fed_cmd_t;

endpackage

`default_nettype wire

[src/fed_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fed_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/fed_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module fed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[src/fed_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fed_ctrl
    import fed_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output fed_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (slot_free)
                begin
                    cmd.wb     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.wb)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[src/fed_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module fed_datapath
    import fed_pkg::*;
#(
    parameter int MAX_DELAY = 65536
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire fed_cmd_t  cmd,
    input  wire in_item_t  in_data,
    input  wire logic      cfg_valid,
    input  wire cfg_item_t cfg_data,
    output out_item_t      out_data
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = $clog2(MAX_DELAY + 1);
    localparam int RST_LEN = (RST_DELAY_LENGTH > MAX_DELAY) ? MAX_DELAY : RST_DELAY_LENGTH;
    localparam logic [31:0] MAX_D32 = 32'(MAX_DELAY);

    // configuration
    logic [LW-1:0]      len_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic [WET_W-1:0]   wet_reg;
    logic [LW-1:0]      len_next;
    logic [WET_W-1:0]   wet_next;

    // delay line position and written-entry mark
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [LW-1:0] hw_reg;
    logic [LW-1:0] hw_next;
    logic [LW-1:0] idx_inc;
    logic          hit;

    // arithmetic
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       be_reg;
    logic        [SAMPLE_W-1:0] rdata;
    logic signed [SAMPLE_W-1:0] d;
    logic signed [15:0]         decay_s;
    logic signed [16:0]         wet_s;
    logic signed [31:0]         p1_reg;
    logic signed [48:0]         p2_reg;
    logic signed [48:0]         round_sum;
    logic signed [18:0]         q;
    logic signed [19:0]         y_wide;
    logic signed [SAMPLE_W-1:0] y;
    out_item_t                  out_reg;

    always_comb
    begin
        len_next = LW'(cfg_data.value);
        if (cfg_data.value == '0)
        begin
            len_next = LW'(1);
        end
        else if (32'(cfg_data.value) > MAX_D32)
        begin
            len_next = LW'(MAX_DELAY);
        end
        wet_next = cfg_data.value[WET_W-1:0];
        if (wet_next > WET_ONE)
        begin
            wet_next = WET_ONE;
        end
    end

    assign idx_inc = LW'(idx_reg) + LW'(1);
    assign hit     = LW'(idx_reg) < hw_reg;

    always_comb
    begin
        idx_next = idx_reg;
        hw_next  = hw_reg;
        if (cfg_valid && cfg_data.index == REG_DELAY_LENGTH)
        begin
            idx_next = '0;
        end
        else if (cmd.wb)
        begin
            idx_next = (idx_inc >= len_reg) ? '0 : AW'(idx_inc);
            if (idx_inc > hw_reg)
            begin
                hw_next = idx_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LW'(RST_LEN);
            decay_reg <= RST_DECAY_GAIN;
            wet_reg   <= RST_WET_MIX;
            idx_reg   <= '0;
            hw_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_data.index)
                    REG_DELAY_LENGTH: len_reg <= len_next;
                    REG_DECAY_GAIN:   decay_reg <= cfg_data.value[DECAY_W-1:0];
                    REG_WET_MIX:      wet_reg <= wet_next;
                    default:          ;
                endcase
            end
            idx_reg <= idx_next;
            hw_reg  <= hw_next;
        end
    end

    fed_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_delay_ram (
        .clk   (clk),
        .we    (cmd.wb),
        .re    (cmd.accept),
        .addr  (idx_reg),
        .wdata (y),
        .rdata (rdata)
    );

    // y = x + round(wet * decay * d / 2^30); the dry and wet x terms sum to x
    assign d       = hit ? $signed(rdata) : '0;
    assign decay_s = $signed({1'b0, decay_reg});
    assign wet_s   = $signed({1'b0, wet_reg});

    assign round_sum = p2_reg + 49'sd536870912;
    assign q         = round_sum[48:30];
    assign y_wide    = {q[18], q} + {{4{x_reg[15]}}, x_reg};

    always_comb
    begin
        if (y_wide > 20'sd32767)
        begin
            y = 16'sh7FFF;
        end
        else if (y_wide < -20'sd32768)
        begin
            y = 16'sh8000;
        end
        else
        begin
            y = y_wide[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg  <= in_data.sample_in;
            be_reg <= in_data.block_end_in;
        end
        if (cmd.mul1)
        begin
            p1_reg <= 32'(decay_s) * 32'(d);
        end
        if (cmd.mul2)
        begin
            p2_reg <= 49'(wet_s) * 49'(p1_reg);
        end
        if (cmd.wb)
        begin
            out_reg.sample_out    <= y;
            out_reg.block_end_out <= be_reg;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

[src/feedback_echo_delay.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Payload                        Handshake
// samples   in    sample_in, block_end_in        valid/ready
// echoes    out   sample_out, block_end_out      valid/ready
// cfg       in    index, value                   valid/ready (ready always high)
//
// Items are taken one at a time: accept with delay-line read, feedback
// multiply, wet multiply, then round/saturate with write-back; the single
// RAM port and the two chained multiplies set this sequence.
// Reset is asynchronous. Delay-line RAM is not swept; entries at or above the
// high-water mark of writes since reset read as zero.
// The result waits in an output register; the next item is accepted meanwhile,
// and write-back waits while the previous result is still untaken.

module feedback_echo_delay
    import fed_pkg::*;
#(
    parameter int MAX_DELAY = 65536
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fed_stream_if.sink   samples,
    fed_stream_if.source echoes,
    fed_stream_if.sink   cfg
);

    fed_cmd_t cmd;

    assign cfg.ready = 1'b1;

    fed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (echoes.valid),
        .out_ready (echoes.ready),
        .cmd       (cmd)
    );

    fed_datapath #(
        .MAX_DELAY (MAX_DELAY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (samples.data),
        .cfg_valid (cfg.valid && cfg.ready),
        .cfg_data  (cfg.data),
        .out_data  (echoes.data)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.mul1, cmd.mul2, cmd.wb}))
        else $error("more than one datapath command at once");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("item accepted while another is in work");

    a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.mul1 ##1 cmd.mul2)
        else $error("multiply sequence broken");

    a_wb_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |=> echoes.valid)
        else $error("write-back without result");

endmodule

`default_nettype wire

[verif/feedback_echo_delay_tb.sv]
`timescale 1ns / 1ps

module feedback_echo_delay_tb;
    import fed_pkg::*;

    localparam int MAX_DELAY = 65536;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1850;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Predicts the comb filter output and holds the echoes still to come.
    class comb_echo_sb;
        int unsigned        delay_len;
        int unsigned        decay;
        int unsigned        wet;
        int unsigned        tap;
        logic signed [15:0] echo_mem [MAX_DELAY];
        out_item_t          echo_q [$];
        int                 mismatches;

        function new();
            delay_len = RST_DELAY_LENGTH;
            decay = RST_DECAY_GAIN;
            wet = RST_WET_MIX;
            tap = 0;
            foreach (echo_mem[i])
                echo_mem[i] = '0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_item_t w);
            case (w.index)
                REG_DELAY_LENGTH:
                begin
                    delay_len = w.value;
                    if (delay_len == 0)
                        delay_len = 1;
                    if (delay_len > MAX_DELAY)
                        delay_len = MAX_DELAY;
                    tap = 0;
                end
                REG_DECAY_GAIN:
                    decay = w.value[DECAY_W-1:0];
                REG_WET_MIX:
                    wet = (w.value[WET_W-1:0] > WET_ONE) ? WET_ONE : w.value[WET_W-1:0];
                default:
                    ;
            endcase
        endfunction

        function void note_sample(in_item_t it);
            longint    x;
            longint    d;
            longint    wet_path;
            longint    acc;
            longint    y;
            out_item_t e;
            if (tap >= delay_len)
                tap = 0;
            x = $signed(it.sample_in);
            d = echo_mem[tap];
            wet_path = x * 32768 + longint'(decay) * d;
            acc = longint'(wet) * wet_path + longint'(32768 - wet) * x * 32768;
            y = (acc + 64'sd536870912) >>> 30;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            echo_mem[tap] = y[15:0];
            tap++;
            if (tap >= delay_len)
                tap = 0;
            e.sample_out = y[15:0];
            e.block_end_out = it.block_end_in;
            echo_q.push_back(e);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_echo(out_item_t got);
            out_item_t e;
            if (echo_q.size() == 0)
            begin
                report($sformatf("unexpected echo item sample=%0d end=%0b",
                    got.sample_out, got.block_end_out));
                return;
            end
            e = echo_q.pop_front();
            if (got.sample_out !== e.sample_out || got.block_end_out !== e.block_end_out)
                report($sformatf("echo mismatch: exp sample=%0d end=%0b, got sample=%0d end=%0b",
                    e.sample_out, e.block_end_out, got.sample_out, got.block_end_out));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;

    comb_echo_sb sb;

    fed_stream_if #(.T(in_item_t))  sample_ch ();
    fed_stream_if #(.T(out_item_t)) echo_ch ();
    fed_stream_if #(.T(cfg_item_t)) cfg_ch ();

    feedback_echo_delay #(
        .MAX_DELAY(MAX_DELAY)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(sample_ch),
        .echoes (echo_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sd32767;
                1: return -16'sd32768;
                2: return 16'sd0;
                default: return -16'sd1;
            endcase
        end
        else if (r < 40)
            return 16'($urandom_range(0, 2000) - 1000);
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_sample(input logic signed [15:0] s, input logic be);
        in_item_t it;
        int       gap;
        it.sample_in = s;
        it.block_end_in = be;
        sample_ch.valid <= 1'b1;
        sample_ch.data <= it;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_sample(it);
        @(negedge clk);
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Leaves valid high so back-to-back writes go out without valid dropping in between.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_item_t w;
        w.index = idx;
        w.value = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= w;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(w);
        @(negedge clk);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.echo_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && echo_ch.valid && echo_ch.ready)
            sb.check_echo(echo_ch.data);
    end

    initial
    begin
        int stall;
        stall = 0;
        echo_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                echo_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                echo_ch.ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int total;
        int phase;
        int n;
        int r;
        int unsigned len;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: half wet over an empty line gives the input back
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sh5555, 1'b1);
        send_sample(16'shAAAA, 1'b0);

        // zero length reads as one, wet above one clamps; drive into saturation
        drain();
        write_cfg(REG_DELAY_LENGTH, 17'd0);
        write_cfg(REG_DECAY_GAIN, 17'd32767);
        write_cfg(REG_WET_MIX, 17'd65535);
        cfg_ch.valid <= 1'b0;
        repeat (3) send_sample(16'sd32767, 1'b0);
        repeat (3) send_sample(-16'sd32768, 1'b1);
        repeat (2) send_sample(16'sd0, 1'b0);

        // length above the store clamps; fully dry
        drain();
        write_cfg(REG_DELAY_LENGTH, 17'h1FFFF);
        write_cfg(REG_WET_MIX, 17'd0);
        write_cfg(REG_DECAY_GAIN, 17'd0);
        cfg_ch.valid <= 1'b0;
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd12345, 1'b0);

        // unknown register is ignored; exact maximum length, then a short line
        drain();
        write_cfg(REG_UNUSED, 17'h1FFFF);
        write_cfg(REG_DELAY_LENGTH, 17'd65536);
        write_cfg(REG_DELAY_LENGTH, 17'd2);
        write_cfg(REG_DECAY_GAIN, 17'd24576);
        write_cfg(REG_WET_MIX, 17'd32768);
        cfg_ch.valid <= 1'b0;
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b1);

        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS)
        begin
            drain();
            if ($urandom_range(0, 9) < 7)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, 48);
                else if (r < 80)
                    len = $urandom_range(49, 600);
                else if (r < 85)
                    len = 0;
                else if (r < 90)
                    len = MAX_DELAY;
                else if (r < 95)
                    len = $urandom_range(MAX_DELAY + 1, 131071);
                else
                    len = $urandom_range(20000, MAX_DELAY - 1);
                write_cfg(REG_DELAY_LENGTH, CFG_DATA_W'(len));
            end
            if ($urandom_range(0, 1))
            begin
                r = $urandom_range(0, 9);
                write_cfg(REG_DECAY_GAIN, CFG_DATA_W'((r == 0) ? 0 : (r == 1) ? 32767 :
                    $urandom_range(0, 32767)));
            end
            if ($urandom_range(0, 1))
            begin
                r = $urandom_range(0, 9);
                write_cfg(REG_WET_MIX, CFG_DATA_W'((r == 0) ? 0 : (r == 1) ? 32768 :
                    (r == 2) ? $urandom_range(32769, 65535) : $urandom_range(0, 32768)));
            end
            if ($urandom_range(0, 9) == 0)
                write_cfg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 131071)));
            cfg_ch.valid <= 1'b0;

            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            n = $urandom_range(20, 120);
            for (int i = 0; i < n; i++)
            begin
                // hold off until the pipeline is empty, mid-stream
                if (i == n / 2 && (phase == 1 || $urandom_range(0, 9) == 0))
                    drain();
                send_sample(rand_sample(), $urandom_range(0, 3) == 0);
            end
            total += n;
            phase++;
        end

        drain();
        if (sb.mismatches == 0 && sb.echo_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
